// ===== sv/drfsc_pkg.sv =====
// Shared types and constants for the dual reed flow sequence counter.
package drfsc_pkg;

	localparam int CODE_W  = 2;
	localparam int PHASE_W = 2;
	localparam int COUNT_W = 4;
	localparam int CFG_W   = 4;

	typedef logic [CODE_W-1:0]  code_t;
	typedef logic [PHASE_W-1:0] phase_t;
	typedef logic [COUNT_W-1:0] count_t;
	typedef logic [CFG_W-1:0]   cfg_data_t;

	typedef enum logic [0:0] {
		REG_DEBOUNCE = 1'b0,
		REG_TAMPER   = 1'b1
	} reg_index_t;

	localparam code_t CODE_MAGNET = 2'b00;
	localparam code_t CODE_B01    = 2'b01;
	localparam code_t CODE_B10    = 2'b10;
	localparam code_t CODE_B11    = 2'b11;

	localparam phase_t PHASE_LAST = 2'd3;

	localparam cfg_data_t DEBOUNCE_RESET = 4'd2;
	localparam cfg_data_t TAMPER_RESET   = 4'd3;

	typedef struct packed {
		logic   volume_pulse;
		logic   tamper_alarm;
		phase_t current_phase;
	} result_t;

	function automatic code_t expected_code(input phase_t ph);
		code_t c;
		c = CODE_B11;
		case (ph)
			2'd0: c = CODE_B01;
			2'd1: c = CODE_B11;
			2'd2: c = CODE_B10;
			2'd3: c = CODE_B11;
			default: c = CODE_B11;
		endcase
		return c;
	endfunction

endpackage

// ===== sv/drfsc_core.sv =====
// Sequence state, magnet counter and configuration registers of the counter.
module drfsc_core (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   write_en,
	input  drfsc_pkg::reg_index_t  reg_index,
	input  drfsc_pkg::cfg_data_t   write_data,
	input  logic                   step,
	input  drfsc_pkg::code_t       code,
	output drfsc_pkg::result_t     result
);
	import drfsc_pkg::*;

	cfg_data_t debounce_q, tamper_q;
	phase_t    phase_q, phase_d;
	count_t    match_q, match_d;
	count_t    magnet_q, magnet_d;
	count_t    match_inc, magnet_inc;
	logic      pulse, alarm;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RESET;
			tamper_q   <= TAMPER_RESET;
		end else if (write_en) begin
			case (reg_index)
				REG_DEBOUNCE: debounce_q <= write_data;
				REG_TAMPER:   tamper_q   <= write_data;
				default: ;
			endcase
		end
	end

	assign match_inc  = match_q + count_t'(1);
	assign magnet_inc = magnet_q + count_t'(1);

	always_comb begin
		phase_d  = phase_q;
		match_d  = match_q;
		magnet_d = magnet_q;
		pulse    = 1'b0;
		alarm    = 1'b0;
		if (code == CODE_MAGNET) begin
			if (magnet_inc >= tamper_q) begin
				magnet_d = '0;
				alarm    = 1'b1;
			end else begin
				magnet_d = magnet_inc;
			end
		end else if (code == expected_code(phase_q)) begin
			if (match_inc >= debounce_q) begin
				match_d = '0;
				pulse   = (phase_q == PHASE_LAST);
				phase_d = phase_q + phase_t'(1);
			end else begin
				match_d = match_inc;
			end
		end else begin
			match_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= '0;
			match_q  <= '0;
			magnet_q <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			match_q  <= match_d;
			magnet_q <= magnet_d;
		end
	end

	assign result.volume_pulse  = pulse;
	assign result.tamper_alarm  = alarm;
	assign result.current_phase = phase_d;

endmodule

// ===== sv/dual_reed_flow_sequence_counter.sv =====
// Top level: input register, sequence core and output register.
// A sample goes from the input register through the core into the output register.
// Throughput: one sample per cycle while the output is not stalled; the core updates its state in a single pass.
// in_ready stays high while the input stage is empty or moving on.
// Reset clears valid flags, phase, match and magnet counts; debounce 2, tamper 3.
module dual_reed_flow_sequence_counter (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  drfsc_pkg::code_t      switch_code,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic                  volume_pulse,
	output logic                  tamper_alarm,
	output drfsc_pkg::phase_t     current_phase,
	input  logic                  write_en,
	input  drfsc_pkg::reg_index_t reg_index,
	input  drfsc_pkg::cfg_data_t  write_data
);
	import drfsc_pkg::*;

	logic    valid_s1;
	code_t   code_s1;
	logic    out_valid_q;
	result_t result_q;
	result_t core_result;
	logic    advance;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			code_s1 <= switch_code;
		end
	end

	drfsc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.write_en   (write_en),
		.reg_index  (reg_index),
		.write_data (write_data),
		.step       (valid_s1 && advance),
		.code       (code_s1),
		.result     (core_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= core_result;
		end
	end

	assign out_valid     = out_valid_q;
	assign volume_pulse  = result_q.volume_pulse;
	assign tamper_alarm  = result_q.tamper_alarm;
	assign current_phase = result_q.current_phase;

	a_pulse_alarm_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(result_q.volume_pulse && result_q.tamper_alarm))
		else $error("pulse and alarm on one transaction");

	a_pulse_wraps_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && result_q.volume_pulse) |-> (result_q.current_phase == '0))
		else $error("volume pulse without return to first phase");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(code_s1)))
		else $error("input stage lost a stalled transaction");

endmodule
